>>> rtl/core/serial_line_editor_tokenizer_unit_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef SERIAL_LINE_EDITOR_TOKENIZER_UNIT_DEFINES_SVH
`define SERIAL_LINE_EDITOR_TOKENIZER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SLET_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("slet: assertion failed");
`define SLET_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
    else $error("slet: implication failed");
`else
`define SLET_ASSERT(lbl, clk, rstn, prop)
`define SLET_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/slet_pkg.sv
package slet_pkg;

  localparam int unsigned LineBufferLenDefault = 64;
  localparam int unsigned MaxTokensDefault     = 16;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  typedef enum logic [2:0] {
    KIND_ECHO  = 3'd0,
    KIND_ERASE = 3'd1,
    KIND_FULL  = 3'd2,
    KIND_LINE  = 3'd3,
    KIND_TOKEN = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_CAP,
    ST_LE_OUT,
    ST_EM_RD,
    ST_EM_CAP,
    ST_EM_LAST
  } state_e;

  typedef struct packed {
    logic take;
    logic rd;
    logic cnt_cap;
    logic le_load;
    logic em_step;
    logic em_last;
  } slet_cmd_t;

  typedef struct packed {
    logic is_eol;
    logic idx_done;
    logic no_tokens;
    logic out_free;
  } slet_stat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

>>> rtl/core/slet_ram.sv
module slet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/slet_ctrl.sv
`include "serial_line_editor_tokenizer_unit_defines.svh"

module slet_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  slet_pkg::slet_stat_t stat_i,
  output slet_pkg::slet_cmd_t  cmd_o,
  output logic               in_stall_o
);
  import slet_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && stat_i.out_free && stat_i.is_eol) state_d = ST_CNT_RD;
      end
      ST_CNT_RD: begin
        state_d = stat_i.idx_done ? ST_LE_OUT : ST_CNT_CAP;
      end
      ST_CNT_CAP: state_d = ST_CNT_RD;
      ST_LE_OUT: begin
        if (stat_i.out_free) state_d = stat_i.no_tokens ? ST_IDLE : ST_EM_RD;
      end
      ST_EM_RD: begin
        state_d = stat_i.idx_done ? ST_EM_LAST : ST_EM_CAP;
      end
      ST_EM_CAP: begin
        if (stat_i.out_free) state_d = ST_EM_RD;
      end
      ST_EM_LAST: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !stat_i.out_free;
        cmd_o.take = in_valid_i && stat_i.out_free;
      end
      ST_CNT_RD:  cmd_o.rd = !stat_i.idx_done;
      ST_CNT_CAP: cmd_o.cnt_cap = 1'b1;
      ST_LE_OUT:  cmd_o.le_load = stat_i.out_free;
      ST_EM_RD:   cmd_o.rd = !stat_i.idx_done;
      ST_EM_CAP:  cmd_o.em_step = stat_i.out_free;
      ST_EM_LAST: cmd_o.em_last = stat_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `SLET_ASSERT_IMP(a_eol_starts_scan, clk_i, rst_ni, cmd_o.take && stat_i.is_eol,
                   ##1 (state_q == ST_CNT_RD))
  `SLET_ASSERT_IMP(a_load_needs_slot, clk_i, rst_ni,
                   cmd_o.take || cmd_o.le_load || cmd_o.em_step || cmd_o.em_last,
                   stat_i.out_free)

endmodule

>>> rtl/core/slet_datapath.sv
`include "serial_line_editor_tokenizer_unit_defines.svh"

module slet_datapath #(
  parameter int unsigned LINE_BUFFER_LEN = slet_pkg::LineBufferLenDefault,
  parameter int unsigned MAX_TOKENS      = slet_pkg::MaxTokensDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           rx_char_i,
  input  slet_pkg::slet_cmd_t  cmd_i,
  output slet_pkg::slet_stat_t stat_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [2:0]           kind_o,
  output logic [7:0]           char_out_o,
  output logic [3:0]           token_number_o,
  output logic                 token_end_o,
  output logic [4:0]           token_count_o,
  output logic                 tokens_dropped_o,
  output logic                 last_o
);
  import slet_pkg::*;

  localparam int unsigned FILL_W = $clog2(LINE_BUFFER_LEN);
  localparam int unsigned CNT_W  = $clog2(MAX_TOKENS + 2);
  localparam logic [FILL_W-1:0] FILL_CAP = FILL_W'(LINE_BUFFER_LEN - 1);
  localparam logic [CNT_W-1:0]  TOK_MAX  = CNT_W'(MAX_TOKENS);
  localparam logic [CNT_W-1:0]  TOK_OVER = CNT_W'(MAX_TOKENS + 1);

  logic [FILL_W-1:0] fill_q, fill_d, idx_q, idx_d;
  logic [CNT_W-1:0]  ntok_q, ntok_d, tok_q, tok_d, pend_tok_q, pend_tok_d;
  logic              prev_blank_q, prev_blank_d, pend_v_q, pend_v_d;
  logic [7:0]        pend_char_q, pend_char_d;
  logic              out_valid_q, out_valid_d;
  kind_e             kind_q, kind_d;
  logic [7:0]        char_q, char_d;
  logic [3:0]        tnum_q, tnum_d;
  logic              tend_q, tend_d, dropped_q, dropped_d, last_q, last_d;
  logic [4:0]        tcount_q, tcount_d;

  logic              ram_we;
  logic [7:0]        rd_data;
  logic              is_eol, is_bs, rd_blank, dropped, pend_kept, out_free;
  logic [CNT_W-1:0]  kept, kept_m1;

  slet_ram #(
    .WIDTH(8),
    .DEPTH(LINE_BUFFER_LEN)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q),
    .wdata_i(rx_char_i),
    .re_i   (cmd_i.rd),
    .raddr_i(idx_q),
    .rdata_o(rd_data)
  );

  assign is_eol    = (rx_char_i == CH_CR) || (rx_char_i == CH_LF);
  assign is_bs     = (rx_char_i == CH_BS);
  assign rd_blank  = is_blank(rd_data);
  assign dropped   = (ntok_q == TOK_OVER);
  assign kept      = dropped ? TOK_MAX : ntok_q;
  assign kept_m1   = CNT_W'(kept - CNT_W'(1));
  assign pend_kept = pend_v_q && (pend_tok_q != TOK_MAX);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign ram_we    = cmd_i.take && !is_eol && !is_bs && (fill_q != FILL_CAP);

  assign stat_o.is_eol    = is_eol;
  assign stat_o.idx_done  = (idx_q == fill_q);
  assign stat_o.no_tokens = (ntok_q == '0);
  assign stat_o.out_free  = out_free;

  // scan and line state
  always_comb begin
    fill_d       = fill_q;
    idx_d        = idx_q;
    ntok_d       = ntok_q;
    tok_d        = tok_q;
    prev_blank_d = prev_blank_q;
    pend_v_d     = pend_v_q;
    pend_char_d  = pend_char_q;
    pend_tok_d   = pend_tok_q;
    if (cmd_i.take) begin
      if (is_eol) begin
        idx_d        = '0;
        ntok_d       = '0;
        prev_blank_d = 1'b1;
      end else if (is_bs) begin
        if (fill_q != '0) fill_d = fill_q - 1'b1;
      end else if (fill_q != FILL_CAP) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (cmd_i.cnt_cap) begin
      if (!rd_blank && prev_blank_q && !dropped) ntok_d = ntok_q + 1'b1;
      prev_blank_d = rd_blank;
      idx_d        = idx_q + 1'b1;
    end
    if (cmd_i.le_load) begin
      idx_d        = '0;
      tok_d        = '0;
      prev_blank_d = 1'b1;
      pend_v_d     = 1'b0;
      if (ntok_q == '0) fill_d = '0;
    end
    if (cmd_i.em_step) begin
      pend_v_d = !rd_blank;
      if (!rd_blank) begin
        pend_char_d = rd_data;
        // a new token starts after a blank or at the line head
        if (prev_blank_q) begin
          pend_tok_d = tok_q;
          if (tok_q != TOK_MAX) tok_d = tok_q + 1'b1;
        end
      end
      prev_blank_d = rd_blank;
      idx_d        = idx_q + 1'b1;
    end
    if (cmd_i.em_last) begin
      pend_v_d = 1'b0;
      fill_d   = '0;
      idx_d    = '0;
    end
  end

  // result register
  always_comb begin
    logic ld;
    ld        = 1'b0;
    kind_d    = kind_q;
    char_d    = char_q;
    tnum_d    = tnum_q;
    tend_d    = tend_q;
    tcount_d  = tcount_q;
    dropped_d = dropped_q;
    last_d    = last_q;
    if (cmd_i.take && !is_eol) begin
      ld        = !is_bs || (fill_q != '0);
      kind_d    = is_bs ? KIND_ERASE : ((fill_q != FILL_CAP) ? KIND_ECHO : KIND_FULL);
      char_d    = (!is_bs && (fill_q != FILL_CAP)) ? rx_char_i : 8'h00;
      tnum_d    = '0;
      tend_d    = 1'b0;
      tcount_d  = '0;
      dropped_d = 1'b0;
      last_d    = 1'b1;
    end
    if (cmd_i.le_load) begin
      ld        = 1'b1;
      kind_d    = KIND_LINE;
      char_d    = 8'h00;
      tnum_d    = '0;
      tend_d    = 1'b0;
      tcount_d  = 5'(kept);
      dropped_d = dropped;
      last_d    = (ntok_q == '0);
    end
    if ((cmd_i.em_step || cmd_i.em_last) && pend_kept) begin
      ld        = 1'b1;
      kind_d    = KIND_TOKEN;
      char_d    = pend_char_q;
      tnum_d    = 4'(pend_tok_q);
      tend_d    = cmd_i.em_last || rd_blank;
      tcount_d  = '0;
      dropped_d = 1'b0;
      last_d    = (cmd_i.em_last || rd_blank) && (pend_tok_q == kept_m1);
    end
    out_valid_d = ld || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      idx_q        <= '0;
      ntok_q       <= '0;
      tok_q        <= '0;
      prev_blank_q <= 1'b1;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      idx_q        <= idx_d;
      ntok_q       <= ntok_d;
      tok_q        <= tok_d;
      prev_blank_q <= prev_blank_d;
      pend_v_q     <= pend_v_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_char_q <= pend_char_d;
    pend_tok_q  <= pend_tok_d;
    kind_q      <= kind_d;
    char_q      <= char_d;
    tnum_q      <= tnum_d;
    tend_q      <= tend_d;
    tcount_q    <= tcount_d;
    dropped_q   <= dropped_d;
    last_q      <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign char_out_o       = char_q;
  assign token_number_o   = tnum_q;
  assign token_end_o      = tend_q;
  assign token_count_o    = tcount_q;
  assign tokens_dropped_o = dropped_q;
  assign last_o           = last_q;

  `SLET_ASSERT(a_fill_cap, clk_i, rst_ni, fill_q <= FILL_CAP)
  `SLET_ASSERT(a_idx_in_line, clk_i, rst_ni, idx_q <= fill_q)
  `SLET_ASSERT_IMP(a_token_kept, clk_i, rst_ni, out_valid_q && (kind_q == KIND_TOKEN),
                   (5'(tnum_q) < 5'(MAX_TOKENS)))

endmodule

>>> rtl/core/serial_line_editor_tokenizer_unit.sv
// Serial line editor and tokenizer. Each received character is one item on the
// input channel; ordinary characters are stored (up to LINE_BUFFER_LEN - 1) and
// echoed, backspace erases, and CR or LF closes the line: a line-end result with
// the token count comes first, then every kept token character with its token
// number and end mark, and the line is cleared. Ordinary characters and
// backspace can follow each other back to back while the output is not stalled. A
// line end holds off further input, also through any output stall: the line
// store has a single read port with registered read, and the line is walked
// twice (count, then emit), with each character read and then captured. No input
// is taken during that walk.
module serial_line_editor_tokenizer_unit #(
  parameter int unsigned LINE_BUFFER_LEN = slet_pkg::LineBufferLenDefault,
  parameter int unsigned MAX_TOKENS      = slet_pkg::MaxTokensDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] char_out_o,
  output logic [3:0] token_number_o,
  output logic       token_end_o,
  output logic [4:0] token_count_o,
  output logic       tokens_dropped_o,
  output logic       last_o
);
  import slet_pkg::*;

  slet_cmd_t  cmd;
  slet_stat_t stat;

  slet_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  slet_datapath #(
    .LINE_BUFFER_LEN(LINE_BUFFER_LEN),
    .MAX_TOKENS     (MAX_TOKENS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_char_i       (rx_char_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .char_out_o      (char_out_o),
    .token_number_o  (token_number_o),
    .token_end_o     (token_end_o),
    .token_count_o   (token_count_o),
    .tokens_dropped_o(tokens_dropped_o),
    .last_o          (last_o)
  );

endmodule

>>> test/serial_line_editor_tokenizer_unit_tb.sv
`timescale 1ns / 100ps

module serial_line_editor_tokenizer_unit_tb;
  import slet_pkg::*;

  localparam int unsigned LineLen     = LineBufferLenDefault;
  localparam int unsigned TokMax      = MaxTokensDefault;
  localparam int unsigned DrainCycles = 4 * LineLen + 40;
  localparam int unsigned ItemTarget  = 440;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [3:0] tnum;
    logic       tend;
    logic [4:0] tcount;
    logic       tdrop;
    logic       last;
  } edit_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] kind_o;
  logic [7:0] char_out_o;
  logic [3:0] token_number_o;
  logic       token_end_o;
  logic [4:0] token_count_o;
  logic       tokens_dropped_o;
  logic       last_o;

  edit_result_t pending_results[$];
  logic [7:0]   shadow_line[LineLen];
  int unsigned  shadow_fill;
  int unsigned  mismatches;
  int unsigned  items_done;
  bit           quiet;

  serial_line_editor_tokenizer_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_char_i       (rx_char_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .char_out_o      (char_out_o),
    .token_number_o  (token_number_o),
    .token_end_o     (token_end_o),
    .token_count_o   (token_count_o),
    .tokens_dropped_o(tokens_dropped_o),
    .last_o          (last_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit blank_char(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  // Work out the results of one accepted character and advance the shadow line.
  function automatic int unsigned editor_predict(input logic [7:0] c);
    edit_result_t r;
    edit_result_t q[$];
    int unsigned  ntok;
    int unsigned  cur;
    ntok = 0;
    cur  = 0;
    if (c == CH_CR || c == CH_LF) begin
      for (int unsigned i = 0; i < shadow_fill; i++) begin
        if (blank_char(shadow_line[i])) continue;
        if (i == 0 || blank_char(shadow_line[i - 1])) begin
          cur = ntok;
          ntok++;
        end
        if (cur < TokMax) begin
          r        = '0;
          r.kind   = KIND_TOKEN;
          r.ch     = shadow_line[i];
          r.tnum   = 4'(cur);
          r.tend   = (i + 1 >= shadow_fill) || blank_char(shadow_line[i + 1]);
          q.push_back(r);
        end
      end
      r        = '0;
      r.kind   = KIND_LINE;
      r.tcount = 5'((ntok > TokMax) ? TokMax : ntok);
      r.tdrop  = (ntok > TokMax);
      q.push_front(r);
      shadow_fill = 0;
    end else if (c == CH_BS) begin
      if (shadow_fill > 0) begin
        shadow_fill--;
        r      = '0;
        r.kind = KIND_ERASE;
        q.push_back(r);
      end
    end else begin
      r = '0;
      if (shadow_fill < LineLen - 1) begin
        shadow_line[shadow_fill] = c;
        shadow_fill++;
        r.kind = KIND_ECHO;
        r.ch   = c;
      end else begin
        r.kind = KIND_FULL;
      end
      q.push_back(r);
    end
    if (q.size() > 0) begin
      r      = q[q.size() - 1];
      r.last = 1'b1;
      q[q.size() - 1] = r;
    end
    foreach (q[k]) pending_results.push_back(q[k]);
    return q.size();
  endfunction

  function automatic logic [7:0] rand_ordinary();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_CR || c == CH_LF || c == CH_BS);
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] rand_line_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18) return rand_blank();
    if (r < 24) return CH_BS;
    return rand_ordinary();
  endfunction

  // Called at a rising edge; returns at the rising edge that accepts the item.
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_char_i  <= c;
    do begin
      @(negedge clk_i);
    end while (in_stall_o);
    void'(editor_predict(c));
    items_done++;
    @(posedge clk_i);
  endtask

  // Hold the sender until every expected result is back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_echo_extremes();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'h41);
    send_char(CH_BS);
    send_char(CH_BS);
    send_char(CH_CR);
  endtask

  task automatic test_empty_line();
    send_char(CH_BS);
    send_char(CH_CR);
    send_char(CH_LF);
  endtask

  task automatic test_whitespace_split();
    send_char(CH_SP);
    send_char(CH_TAB);
    send_char(8'h61);
    send_char(8'h62);
    send_char(CH_VT);
    send_char(CH_FF);
    send_char(CH_SP);
    send_char(8'h63);
    send_char(CH_TAB);
    send_char(CH_LF);
    send_char(8'h78);
    send_char(CH_CR);
  endtask

  task automatic test_capacity();
    // fill to capacity, overrun twice, erase one and refill
    for (int unsigned i = 0; i < LineLen - 1; i++) begin
      send_char(($urandom_range(0, 7) == 0) ? rand_blank() : rand_ordinary());
    end
    send_char(rand_ordinary());
    send_char(rand_ordinary());
    send_char(CH_BS);
    send_char(rand_ordinary());
    send_char(CH_CR);
    // more tokens than kept, then exactly the maximum
    for (int unsigned i = 0; i < TokMax + 4; i++) begin
      send_char(rand_ordinary());
      send_char(rand_blank());
    end
    send_char(CH_LF);
    for (int unsigned i = 0; i < TokMax; i++) begin
      send_char(rand_blank());
      send_char(rand_ordinary());
    end
    send_char(CH_CR);
  endtask

  task automatic test_random_lines();
    int unsigned mode;
    int unsigned len;
    while (items_done < ItemTarget) begin
      mode  = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 4) == 0);
      if (mode == 0) begin
        len = $urandom_range(1, 10);
        repeat (len) send_char(8'($urandom_range(0, 255)));
      end else if (mode == 1) begin
        len = $urandom_range(40, 70);
        repeat (len) send_char(rand_line_char());
      end else if (mode == 2) begin
        len = $urandom_range(28, 50);
        repeat (len) send_char($urandom_range(0, 1) ? rand_blank() : rand_ordinary());
      end else begin
        len = $urandom_range(0, 14);
        repeat (len) send_char(rand_line_char());
      end
      if (mode != 0) send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
    end
    quiet = 1'b0;
  endtask

  task automatic note_failure(input string what, input edit_result_t want,
                              input edit_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind=%0d ch=%02h tnum=%0d end=%0b cnt=%0d drop=%0b last=%0b",
               what, want.kind, want.ch, want.tnum, want.tend, want.tcount, want.tdrop,
               want.last);
      $display("  actual   kind=%0d ch=%02h tnum=%0d end=%0b cnt=%0d drop=%0b last=%0b",
               got.kind, got.ch, got.tnum, got.tend, got.tcount, got.tdrop, got.last);
    end
  endtask

  initial begin : output_pacing
    int unsigned n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do begin
        @(negedge clk_i);
      end while (!(out_valid_o && !out_stall_i));
      @(posedge clk_i);
    end
  end

  always begin : result_check
    edit_result_t got;
    edit_result_t want;
    @(negedge clk_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind   = kind_e'(kind_o);
      got.ch     = char_out_o;
      got.tnum   = token_number_o;
      got.tend   = token_end_o;
      got.tcount = token_count_o;
      got.tdrop  = tokens_dropped_o;
      got.last   = last_o;
      @(posedge clk_i);
      if (pending_results.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.ch !== want.ch || got.tnum !== want.tnum ||
            got.tend !== want.tend || got.tcount !== want.tcount ||
            got.tdrop !== want.tdrop || got.last !== want.last) begin
          note_failure("result mismatch", want, got);
        end
      end
    end
  end

  initial begin : regression
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_char_i   = 8'h00;
    out_stall_i = 1'b0;
    shadow_fill = 0;
    mismatches  = 0;
    items_done  = 0;
    quiet       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_echo_extremes();
    test_empty_line();
    test_whitespace_split();
    test_capacity();
    wait_drained();
    test_random_lines();
    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> serial_line_editor_tokenizer_unit.f
+incdir+rtl/core
rtl/core/slet_pkg.sv
rtl/core/slet_ram.sv
rtl/core/slet_ctrl.sv
rtl/core/slet_datapath.sv
rtl/core/serial_line_editor_tokenizer_unit.sv
test/serial_line_editor_tokenizer_unit_tb.sv
